FILE: src/indexed_list_array_macros.svh
// ----------------------------------------------------------------------------
// Indexed list array assertion macros
// Shared forms for the concurrent checks on the list store ports.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ARRAY_MACROS_SVH
`define INDEXED_LIST_ARRAY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ILA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ila_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list array package
// Field widths, operation and status codes, and the structs shared by the
// control unit and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ila_pkg;

  localparam int ILA_DEPTH  = 64;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 8;
  localparam int OP_W       = 2;
  localparam int CNT_OUT_W  = 7;
  localparam int STS_W      = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;
  localparam logic [OP_W-1:0] OP_SET    = 2'd3;

  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [POS_W-1:0] POS_END = -8'sd1;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;
  } ila_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]     element_count;
    logic [STS_W-1:0]         status;
  } ila_res_t;

  typedef struct packed {
    logic     idle;
    logic     done;
    ila_res_t res;
  } ila_stat_t;

endpackage

FILE: src/ila_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ila_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ila_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed list array control unit
// Checks the position, then steps one pointer through the store to move
// entries up or down, read or write, and keeps the element count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ila_ctrl import ila_pkg::*; #(
  parameter int DEPTH = ILA_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ila_req_t  req,
  input  logic      take,
  output ila_stat_t stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 7) ? CW + 1 : 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_WRITE,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            ptr_r, ptr_nxt;
  logic [AW-1:0]            at_r, at_nxt;
  logic [AW-1:0]            pend_addr_r, pend_addr_nxt;
  logic                     pend_r, pend_nxt;
  logic                     more_r, more_nxt;
  logic [OP_W-1:0]          op_r, op_nxt;
  logic [DATA_W-1:0]        val_r, val_nxt;
  logic [DATA_W-1:0]        rd_r, rd_nxt;
  logic [STS_W-1:0]         sts_r, sts_nxt;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [DATA_W-1:0]        ram_rdata;

  logic                     pos_end;
  logic [XW-1:0]            pos_ext;
  logic [XW-1:0]            cnt_ext;
  logic [CW-1:0]            cnt_dec;
  logic [AW-1:0]            cnt_last;
  logic                     ins_ok;
  logic                     oth_ok;
  logic                     full;
  logic [AW-1:0]            at_ins;
  logic [AW-1:0]            at_oth;

  assign pos_end  = (req.position == POS_END);
  assign pos_ext  = XW'(req.position[POS_W-2:0]);
  assign cnt_ext  = XW'(count_r);
  assign cnt_dec  = count_r - CW'(1);
  assign cnt_last = cnt_dec[AW-1:0];
  assign ins_ok   = pos_end || (!req.position[POS_W-1] && (pos_ext <= cnt_ext));
  assign oth_ok   = (pos_end && (count_r != '0)) ||
                    (!req.position[POS_W-1] && (pos_ext < cnt_ext));
  assign full     = (count_r == CW'(DEPTH));
  assign at_ins   = pos_end ? count_r[AW-1:0] : pos_ext[AW-1:0];
  assign at_oth   = pos_end ? cnt_last : pos_ext[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    at_nxt        = at_r;
    pend_addr_nxt = pend_addr_r;
    pend_nxt      = pend_r;
    more_nxt      = more_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    rd_nxt        = rd_r;
    sts_nxt       = sts_r;
    ram_we        = 1'b0;
    ram_waddr     = at_r;
    ram_wdata     = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = req.operation;
          val_nxt  = req.value;
          rd_nxt   = '0;
          sts_nxt  = ST_OK;
          pend_nxt = 1'b0;
          more_nxt = 1'b1;
          if (req.operation == OP_INSERT) begin
            at_nxt = at_ins;
            if (!ins_ok) begin
              sts_nxt   = ST_RANGE;
              state_nxt = S_DONE;
            end else if (full) begin
              sts_nxt   = ST_FULL;
              state_nxt = S_DONE;
            end else if (pos_end || (pos_ext == cnt_ext)) begin
              state_nxt = S_WRITE;
            end else begin
              ptr_nxt   = cnt_last;
              state_nxt = S_SHIFT_UP;
            end
          end else if (!oth_ok) begin
            sts_nxt   = ST_RANGE;
            state_nxt = S_DONE;
          end else begin
            at_nxt = at_oth;
            unique case (req.operation)
              OP_REMOVE: begin
                if (at_oth == cnt_last) begin
                  count_nxt = cnt_dec;
                  state_nxt = S_DONE;
                end else begin
                  ptr_nxt   = at_oth + AW'(1);
                  state_nxt = S_SHIFT_DN;
                end
              end
              OP_GET: begin
                ptr_nxt   = at_oth;
                state_nxt = S_RD_ISSUE;
              end
              default: begin
                state_nxt = S_WRITE;
              end
            endcase
          end
        end
      end
      S_SHIFT_UP: begin
        ram_we    = pend_r;
        ram_waddr = pend_addr_r + AW'(1);
        ram_wdata = ram_rdata;
        if (more_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r;
          if (ptr_r == at_r) begin
            more_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r - AW'(1);
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_WRITE;
        end
      end
      S_SHIFT_DN: begin
        ram_we    = pend_r;
        ram_waddr = pend_addr_r - AW'(1);
        ram_wdata = ram_rdata;
        if (more_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r;
          if (ptr_r == cnt_last) begin
            more_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end else begin
          pend_nxt  = 1'b0;
          count_nxt = cnt_dec;
          state_nxt = S_DONE;
        end
      end
      S_WRITE: begin
        ram_we = 1'b1;
        if (op_r == OP_INSERT) begin
          count_nxt = count_r + CW'(1);
        end
        state_nxt = S_DONE;
      end
      S_RD_ISSUE: begin
        state_nxt = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        rd_nxt    = ram_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      more_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      more_r  <= more_nxt;
    end
    ptr_r       <= ptr_nxt;
    at_r        <= at_nxt;
    pend_addr_r <= pend_addr_nxt;
    op_r        <= op_nxt;
    val_r       <= val_nxt;
    rd_r        <= rd_nxt;
    sts_r       <= sts_nxt;
  end

  ila_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ptr_r),
    .rdata(ram_rdata)
  );

  assign stat.idle              = (state_r == S_IDLE);
  assign stat.done              = (state_r == S_DONE);
  assign stat.res.read_value    = rd_r;
  assign stat.res.element_count = CNT_OUT_W'(count_r);
  assign stat.res.status        = sts_r;

endmodule

FILE: src/indexed_list_array.sv
// ----------------------------------------------------------------------------
// Indexed list array
// Ordered list of signed 32-bit values in a fixed store with insert, remove,
// get and set at a position, and an output register toward the consumer.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   in       in_valid, in_ready   in_operation, in_position, in_value
//   out      out_valid, out_ready out_read_value, out_element_count, out_status
//
// An insert or a remove moves the entries behind its position through the
// store, one entry per cycle; a get, a set, an append, a remove of the last
// entry and a rejected item move no entries.
// After reset the list is empty and no clearing pass is made.
// A result waits in the output register, while the next item is processed;
// that item finishes only once the register is free.
`timescale 1ns / 1ps

module indexed_list_array import ila_pkg::*; #(
  parameter int DEPTH = ILA_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [OP_W-1:0]             in_operation,
  input  logic signed [POS_W-1:0]     in_position,
  input  logic signed [DATA_W-1:0]    in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DATA_W-1:0]    out_read_value,
  output logic [CNT_OUT_W-1:0]        out_element_count,
  output logic [STS_W-1:0]            out_status
);

  ila_req_t  req;
  ila_stat_t stat;
  ila_res_t  out_res_r;
  logic      out_valid_r;
  logic      start;
  logic      take;

  assign req.operation = in_operation;
  assign req.position  = in_position;
  assign req.value     = in_value;

  assign in_ready = stat.idle;
  assign start    = in_valid && in_ready;
  assign take     = stat.done && (!out_valid_r || out_ready);

  ila_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .req  (req),
    .take (take),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (take) begin
      out_res_r <= stat.res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_res_r.read_value;
  assign out_element_count = out_res_r.element_count;
  assign out_status        = out_res_r.status;

endmodule

FILE: src/ila_chk.sv
// ----------------------------------------------------------------------------
// Indexed list array checker
// Port-level checks on the list store, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_list_array_macros.svh"

module ila_chk import ila_pkg::*; #(
  parameter int DEPTH = ILA_DEPTH
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [OP_W-1:0]          in_operation,
  input logic signed [POS_W-1:0]  in_position,
  input logic signed [DATA_W-1:0] in_value,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_read_value,
  input logic [CNT_OUT_W-1:0]     out_element_count,
  input logic [STS_W-1:0]         out_status
);

  `ILA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_read_value) && $stable(out_element_count) && $stable(out_status), "stalled result changed")
  `ILA_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && in_ready, !in_ready, "input ready right after a transfer")
  `ILA_ASSERT_NOW(a_error_no_data, clk, rst_n, out_valid && (out_status != ST_OK), out_read_value == '0, "rejected item returned data")
  `ILA_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && (out_status == ST_FULL), out_element_count == CNT_OUT_W'(DEPTH), "full status with a count below the depth")

endmodule

bind indexed_list_array ila_chk #(.DEPTH(DEPTH)) u_ila_chk (.*);
